FILE: src/touch_trimmed_mean_calibrate_defines.svh
// assertion macros for the touch trimmed mean calibrate block
`ifndef TOUCH_TRIMMED_MEAN_CALIBRATE_DEFINES_SVH
`define TOUCH_TRIMMED_MEAN_CALIBRATE_DEFINES_SVH

`ifndef SYNTHESIS
`define TTMC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TTMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTMC_ASSERT(label, clk, rst, prop, msg)
`define TTMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: src/tmc_pkg.sv
`timescale 1ns / 1ps

package tmc_pkg;

   localparam int SAMPLES     = 10;
   localparam int SAMPLE_W    = 12;
   localparam int SUM_W       = SAMPLE_W + $clog2(SAMPLES);
   localparam int COUNT_W     = $clog2(SAMPLES);
   localparam int DIVISOR     = SAMPLES - 2;
   localparam int RECIP_SHIFT = SUM_W + $clog2(DIVISOR);
   localparam int RECIP_W     = SUM_W + 1;
   localparam int QPROD_W     = SUM_W + RECIP_W;

   localparam int GAIN_W      = 24;
   localparam int OFFSET_W    = 32;
   localparam int OFFSET_FRAC = 8;
   localparam int PROD_W      = GAIN_W + SAMPLE_W + 1;
   localparam int ACC_W       = OFFSET_W + OFFSET_FRAC + 1;
   localparam int CAL_FRAC    = 16;
   localparam int COORD_W     = 16;

   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 5;
   localparam int REG_IDX_W   = 3;

   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = {SAMPLE_W{1'b1}};
   localparam logic [SUM_W-1:0]    TRIM_MAX   = SUM_W'(DIVISOR * ((1 << SAMPLE_W) - 1));
   localparam logic [COUNT_W-1:0]  LAST_COUNT = COUNT_W'(SAMPLES - 1);
   localparam logic [COORD_W-1:0]  COORD_MAX  = {COORD_W{1'b1}};

   localparam logic [REG_IDX_W-1:0] REG_CAL_ENABLE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_X     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_Y     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y   = 3'd4;

   localparam logic [GAIN_W-1:0]   GAIN_X_RESET   = GAIN_W'(4286);
   localparam logic [OFFSET_W-1:0] OFFSET_X_RESET = OFFSET_W'(-3971);
   localparam logic [GAIN_W-1:0]   GAIN_Y_RESET   = GAIN_W'(-4913);
   localparam logic [OFFSET_W-1:0] OFFSET_Y_RESET = OFFSET_W'(84035);

   typedef struct packed {
      logic                       calibrate_enable;
      logic signed [GAIN_W-1:0]   gain_x;
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [GAIN_W-1:0]   gain_y;
      logic signed [OFFSET_W-1:0] offset_y;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             axis;
      logic [SUM_W-1:0] total;
   } trim_type;

endpackage

FILE: src/tmc_csr.sv
`timescale 1ns / 1ps

module tmc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tmc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [tmc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [tmc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output tmc_pkg::cfg_type              cfg
);

   tmc_pkg::cfg_type                   cfg_ff;
   logic [tmc_pkg::REG_IDX_W-1:0]      reg_idx;
   logic                               wr_en;

   assign reg_idx    = csr_paddr[tmc_pkg::ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calibrate_enable <= 1'b1;
         cfg_ff.gain_x           <= tmc_pkg::GAIN_X_RESET;
         cfg_ff.offset_x         <= tmc_pkg::OFFSET_X_RESET;
         cfg_ff.gain_y           <= tmc_pkg::GAIN_Y_RESET;
         cfg_ff.offset_y         <= tmc_pkg::OFFSET_Y_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            tmc_pkg::REG_CAL_ENABLE: cfg_ff.calibrate_enable <= csr_pwdata[0];
            tmc_pkg::REG_GAIN_X:     cfg_ff.gain_x   <= csr_pwdata[tmc_pkg::GAIN_W-1:0];
            tmc_pkg::REG_OFFSET_X:   cfg_ff.offset_x <= csr_pwdata[tmc_pkg::OFFSET_W-1:0];
            tmc_pkg::REG_GAIN_Y:     cfg_ff.gain_y   <= csr_pwdata[tmc_pkg::GAIN_W-1:0];
            tmc_pkg::REG_OFFSET_Y:   cfg_ff.offset_y <= csr_pwdata[tmc_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tmc_pkg::REG_CAL_ENABLE:
            csr_prdata = {{(tmc_pkg::DATA_W-1){1'b0}}, cfg_ff.calibrate_enable};
         tmc_pkg::REG_GAIN_X:
            csr_prdata = {{(tmc_pkg::DATA_W-tmc_pkg::GAIN_W){cfg_ff.gain_x[tmc_pkg::GAIN_W-1]}},
                          cfg_ff.gain_x};
         tmc_pkg::REG_OFFSET_X:
            csr_prdata = cfg_ff.offset_x;
         tmc_pkg::REG_GAIN_Y:
            csr_prdata = {{(tmc_pkg::DATA_W-tmc_pkg::GAIN_W){cfg_ff.gain_y[tmc_pkg::GAIN_W-1]}},
                          cfg_ff.gain_y};
         tmc_pkg::REG_OFFSET_Y:
            csr_prdata = cfg_ff.offset_y;
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

FILE: src/tmc_accum.sv
`timescale 1ns / 1ps

module tmc_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [tmc_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                           calib_ready,
   output tmc_pkg::trim_type              trim
);

   logic [tmc_pkg::SUM_W-1:0]    sum_ff   [2];
   logic [tmc_pkg::SAMPLE_W-1:0] max_ff   [2];
   logic [tmc_pkg::SAMPLE_W-1:0] min_ff   [2];
   logic [tmc_pkg::COUNT_W-1:0]  count_ff [2];
   tmc_pkg::trim_type            trim_ff;
   tmc_pkg::trim_type            trim_in;

   logic                         accept;
   logic                         last;
   logic                         trim_load;
   logic [tmc_pkg::SUM_W-1:0]    sum_in;
   logic [tmc_pkg::SAMPLE_W-1:0] max_in;
   logic [tmc_pkg::SAMPLE_W-1:0] min_in;
   logic [tmc_pkg::SUM_W-1:0]    total;

   assign req_stall = trim_ff.valid && !calib_ready;
   assign accept    = req_valid && !req_stall;
   assign trim_load = !trim_ff.valid || calib_ready;
   assign trim      = trim_ff;

   assign sum_in = sum_ff[req_func] + tmc_pkg::SUM_W'(req_sample);
   assign max_in = (req_sample > max_ff[req_func]) ? req_sample : max_ff[req_func];
   assign min_in = (req_sample < min_ff[req_func]) ? req_sample : min_ff[req_func];
   assign last   = count_ff[req_func] == tmc_pkg::LAST_COUNT;
   assign total  = sum_in - tmc_pkg::SUM_W'(max_in) - tmc_pkg::SUM_W'(min_in);

   always_comb begin
      trim_in = trim_ff;
      if (trim_load) begin
         trim_in.valid = accept && last;
         trim_in.axis  = req_func;
         trim_in.total = total;
      end
   end

   always_ff @(posedge clock) begin
      trim_ff.axis  <= trim_in.axis;
      trim_ff.total <= trim_in.total;
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            sum_ff[a]   <= '0;
            max_ff[a]   <= '0;
            min_ff[a]   <= tmc_pkg::FULL_SCALE;
            count_ff[a] <= '0;
         end
         trim_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            if (last) begin
               sum_ff[req_func]   <= '0;
               max_ff[req_func]   <= '0;
               min_ff[req_func]   <= tmc_pkg::FULL_SCALE;
               count_ff[req_func] <= '0;
            end else begin
               sum_ff[req_func]   <= sum_in;
               max_ff[req_func]   <= max_in;
               min_ff[req_func]   <= min_in;
               count_ff[req_func] <= count_ff[req_func] + 1'b1;
            end
         end
         trim_ff.valid <= trim_in.valid;
      end
   end

endmodule

FILE: src/tmc_calib.sv
`timescale 1ns / 1ps

module tmc_calib (
   input  logic                           clock,
   input  logic                           reset,
   input  tmc_pkg::trim_type              trim,
   input  tmc_pkg::cfg_type               cfg,
   output logic                           calib_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_axis,
   output logic [tmc_pkg::COORD_W-1:0]    rsp_coordinate
);

   // divide stage
   logic                                  div_valid_ff;
   logic                                  div_axis_ff;
   logic [tmc_pkg::SAMPLE_W-1:0]          mean_ff;
   // gain stage
   logic                                  mul_valid_ff;
   logic                                  mul_axis_ff;
   logic [tmc_pkg::SAMPLE_W-1:0]          mul_mean_ff;
   logic signed [tmc_pkg::PROD_W-1:0]     prod_ff;
   // output stage
   logic                                  rsp_valid_ff;
   logic                                  rsp_axis_ff;
   logic [tmc_pkg::COORD_W-1:0]           rsp_coord_ff;

   logic                                  out_load;
   logic                                  mul_load;
   logic                                  div_load;
   logic [tmc_pkg::QPROD_W-1:0]           qprod;
   logic [tmc_pkg::SAMPLE_W-1:0]          mean_in;
   logic signed [tmc_pkg::GAIN_W-1:0]     gain;
   logic signed [tmc_pkg::SAMPLE_W:0]     mean_s;
   logic signed [tmc_pkg::PROD_W-1:0]     prod_in;
   logic signed [tmc_pkg::OFFSET_W-1:0]   offset;
   logic signed [tmc_pkg::ACC_W-1:0]      acc;
   logic [tmc_pkg::COORD_W-1:0]           coord_in;

   assign out_load    = !rsp_valid_ff || !rsp_stall;
   assign mul_load    = !mul_valid_ff || out_load;
   assign div_load    = !div_valid_ff || mul_load;
   assign calib_ready = div_load;

   // reciprocal multiply, exact over the whole trimmed sum range
   assign qprod   = {{tmc_pkg::RECIP_W{1'b0}}, trim.total} *
                    {{tmc_pkg::SUM_W{1'b0}}, tmc_pkg::RECIP};
   assign mean_in = qprod[tmc_pkg::RECIP_SHIFT +: tmc_pkg::SAMPLE_W];

   assign gain    = div_axis_ff ? cfg.gain_y : cfg.gain_x;
   assign mean_s  = {1'b0, mean_ff};
   assign prod_in = gain * mean_s;

   assign offset  = mul_axis_ff ? cfg.offset_y : cfg.offset_x;
   assign acc     = tmc_pkg::ACC_W'(prod_ff) +
                    tmc_pkg::ACC_W'($signed({offset, {tmc_pkg::OFFSET_FRAC{1'b0}}}));

   always_comb begin
      if (!cfg.calibrate_enable) begin
         coord_in = tmc_pkg::COORD_W'(mul_mean_ff);
      end else if (acc[tmc_pkg::ACC_W-1]) begin
         coord_in = '0;
      end else if (|acc[tmc_pkg::ACC_W-2:tmc_pkg::CAL_FRAC+tmc_pkg::COORD_W]) begin
         coord_in = tmc_pkg::COORD_MAX;
      end else begin
         coord_in = acc[tmc_pkg::CAL_FRAC +: tmc_pkg::COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (div_load) begin
            div_valid_ff <= trim.valid;
         end
         if (mul_load) begin
            mul_valid_ff <= div_valid_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         div_axis_ff <= trim.axis;
         mean_ff     <= mean_in;
      end
      if (mul_load) begin
         mul_axis_ff <= div_axis_ff;
         mul_mean_ff <= mean_ff;
         prod_ff     <= prod_in;
      end
      if (out_load) begin
         rsp_axis_ff  <= mul_axis_ff;
         rsp_coord_ff <= coord_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_axis       = rsp_axis_ff;
   assign rsp_coordinate = rsp_coord_ff;

endmodule

FILE: src/touch_trimmed_mean_calibrate.sv
`timescale 1ns / 1ps
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------
// req       | in        | req_valid/req_stall  | req_func, req_sample
// rsp       | out       | rsp_valid/rsp_stall  | rsp_axis, rsp_coordinate
// csr       | in/out    | csr_psel/csr_penable | csr_paddr, csr_pwdata, csr_prdata
//
// one sample per cycle while req_stall is low; the accumulate step for either axis is registered
// a finished batch's result is registered after accumulate, reciprocal divide,
// gain multiply, and offset and saturate before it is presented on rsp_valid
// reset returns both axis accumulators to their start values and clears the pipeline valid flags
// rsp_stall backs up the four pipeline stages; req_stall rises only when all are full

`include "touch_trimmed_mean_calibrate_defines.svh"

module touch_trimmed_mean_calibrate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [tmc_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_axis,
   output logic [tmc_pkg::COORD_W-1:0]   rsp_coordinate,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tmc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [tmc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [tmc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   tmc_pkg::cfg_type  cfg;
   tmc_pkg::trim_type trim;
   logic              calib_ready;

   tmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tmc_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_sample  (req_sample),
      .calib_ready (calib_ready),
      .trim        (trim)
   );

   tmc_calib u_calib (
      .clock          (clock),
      .reset          (reset),
      .trim           (trim),
      .cfg            (cfg),
      .calib_ready    (calib_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_axis       (rsp_axis),
      .rsp_coordinate (rsp_coordinate)
   );

   `TTMC_ASSERT(trim_total_in_range, clock, reset, !trim.valid || trim.total <= tmc_pkg::TRIM_MAX, "trimmed sum exceeds batch range")
   `TTMC_ASSERT_NEXT(trim_held_on_stall, clock, reset, trim.valid && !calib_ready, trim.valid && $stable(trim.total) && $stable(trim.axis), "stalled trimmed sum changed")

endmodule

FILE: bench/tb_touch_trimmed_mean_calibrate.sv
`timescale 1ns / 1ps

module tb_touch_trimmed_mean_calibrate;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [tmc_pkg::REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

   typedef struct {
      logic                         axis;
      logic [tmc_pkg::COORD_W-1:0]  coordinate;
   } coord_rec_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = 1'b0;
   logic [tmc_pkg::SAMPLE_W-1:0]  req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_axis;
   logic [tmc_pkg::COORD_W-1:0]   rsp_coordinate;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [tmc_pkg::ADDR_W-1:0]    csr_paddr = '0;
   logic [tmc_pkg::DATA_W-1:0]    csr_pwdata = '0;
   logic [tmc_pkg::DATA_W-1:0]    csr_prdata;
   logic                          csr_pready;

   tmc_pkg::cfg_type              cal_cfg;
   int unsigned                   run_sum [2];
   logic [tmc_pkg::SAMPLE_W-1:0]  run_hi [2];
   logic [tmc_pkg::SAMPLE_W-1:0]  run_lo [2];
   int unsigned                   run_len [2];
   coord_rec_type                 coord_due [$];
   int                            error_count = 0;
   int                            cycle_count = 0;
   int                            stall_mode = 0;
   int                            stall_left = 0;

   touch_trimmed_mean_calibrate dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_axis       (rsp_axis),
      .rsp_coordinate (rsp_coordinate),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern: free-running, light, or heavy windows
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin : check_rsp
      coord_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coord_due.size() == 0) begin
            $display("%0t unexpected transaction: expected none actual axis %0d coordinate %0d",
                     $time, rsp_axis, rsp_coordinate);
            error_count++;
         end else begin
            want = coord_due.pop_front();
            if (rsp_axis !== want.axis) begin
               $display("%0t axis mismatch: expected %0d actual %0d",
                        $time, want.axis, rsp_axis);
               error_count++;
            end
            if (rsp_coordinate !== want.coordinate) begin
               $display("%0t coordinate mismatch (axis %0d): expected %0d actual %0d",
                        $time, want.axis, want.coordinate, rsp_coordinate);
               error_count++;
            end
         end
      end
   end

   function automatic void clear_run(int a);
      run_sum[a] = 0;
      run_hi[a]  = '0;
      run_lo[a]  = tmc_pkg::FULL_SCALE;
      run_len[a] = 0;
   endfunction

   function automatic logic [tmc_pkg::COORD_W-1:0] scale_mean(
         int unsigned mean,
         logic signed [tmc_pkg::GAIN_W-1:0] g,
         logic signed [tmc_pkg::OFFSET_W-1:0] o);
      longint acc;
      acc = longint'(g) * longint'(mean) + longint'(o) * 64'sd256;
      if (acc < 0)
         return '0;
      acc = acc >>> tmc_pkg::CAL_FRAC;
      if (acc > longint'(tmc_pkg::COORD_MAX))
         return tmc_pkg::COORD_MAX;
      return acc[tmc_pkg::COORD_W-1:0];
   endfunction

   function automatic void absorb_sample(logic f, logic [tmc_pkg::SAMPLE_W-1:0] s);
      int unsigned   mean;
      coord_rec_type rec;
      run_sum[f] += s;
      if (s > run_hi[f])
         run_hi[f] = s;
      if (s < run_lo[f])
         run_lo[f] = s;
      run_len[f]++;
      if (run_len[f] == tmc_pkg::SAMPLES) begin
         mean = (run_sum[f] - run_hi[f] - run_lo[f]) / tmc_pkg::DIVISOR;
         rec.axis = f;
         if (cal_cfg.calibrate_enable) begin
            if (f == 1'b0)
               rec.coordinate = scale_mean(mean, cal_cfg.gain_x, cal_cfg.offset_x);
            else
               rec.coordinate = scale_mean(mean, cal_cfg.gain_y, cal_cfg.offset_y);
         end else begin
            rec.coordinate = mean[tmc_pkg::COORD_W-1:0];
         end
         coord_due.push_back(rec);
         clear_run(f);
      end
   endfunction

   function automatic void note_register(logic [tmc_pkg::REG_IDX_W-1:0] idx,
                                         logic [tmc_pkg::DATA_W-1:0] v);
      case (idx)
         tmc_pkg::REG_CAL_ENABLE: cal_cfg.calibrate_enable = v[0];
         tmc_pkg::REG_GAIN_X:     cal_cfg.gain_x = v[tmc_pkg::GAIN_W-1:0];
         tmc_pkg::REG_OFFSET_X:   cal_cfg.offset_x = v[tmc_pkg::OFFSET_W-1:0];
         tmc_pkg::REG_GAIN_Y:     cal_cfg.gain_y = v[tmc_pkg::GAIN_W-1:0];
         tmc_pkg::REG_OFFSET_Y:   cal_cfg.offset_y = v[tmc_pkg::OFFSET_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [tmc_pkg::DATA_W-1:0] register_mask(
         logic [tmc_pkg::REG_IDX_W-1:0] idx);
      case (idx)
         tmc_pkg::REG_CAL_ENABLE:                   return 32'h1;
         tmc_pkg::REG_GAIN_X, tmc_pkg::REG_GAIN_Y:  return 32'h00FF_FFFF;
         default:                                   return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [tmc_pkg::DATA_W-1:0] register_value(
         logic [tmc_pkg::REG_IDX_W-1:0] idx);
      case (idx)
         tmc_pkg::REG_CAL_ENABLE: return tmc_pkg::DATA_W'(cal_cfg.calibrate_enable);
         tmc_pkg::REG_GAIN_X:     return tmc_pkg::DATA_W'(cal_cfg.gain_x);
         tmc_pkg::REG_OFFSET_X:   return tmc_pkg::DATA_W'(cal_cfg.offset_x);
         tmc_pkg::REG_GAIN_Y:     return tmc_pkg::DATA_W'(cal_cfg.gain_y);
         default:                 return tmc_pkg::DATA_W'(cal_cfg.offset_y);
      endcase
   endfunction

   function automatic logic [tmc_pkg::SAMPLE_W-1:0] pick_sample(int center);
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = tmc_pkg::FULL_SCALE;
         2, 3, 4: begin
            v = center + $urandom_range(0, 32) - 16;
            if (v < 0)
               v = 0;
            if (v > tmc_pkg::FULL_SCALE)
               v = tmc_pkg::FULL_SCALE;
         end
         default: v = $urandom_range(0, tmc_pkg::FULL_SCALE);
      endcase
      return v[tmc_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic send_sample(input logic f, input logic [tmc_pkg::SAMPLE_W-1:0] s);
      req_valid  <= 1'b1;
      req_func   <= f;
      req_sample <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      absorb_sample(f, s);
   endtask

   task automatic csr_write(input logic [tmc_pkg::REG_IDX_W-1:0] idx,
                            input logic [tmc_pkg::DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      note_register(idx, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [tmc_pkg::REG_IDX_W-1:0] idx);
      logic [tmc_pkg::DATA_W-1:0] mask;
      mask = register_mask(idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if ((csr_prdata & mask) !== (register_value(idx) & mask)) begin
         $display("%0t register %0d readback: expected %h actual %h",
                  $time, idx, register_value(idx) & mask, csr_prdata & mask);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (coord_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic settle_pipeline();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [tmc_pkg::DATA_W-1:0] en,
                                 input logic [tmc_pkg::DATA_W-1:0] gx,
                                 input logic [tmc_pkg::DATA_W-1:0] ox,
                                 input logic [tmc_pkg::DATA_W-1:0] gy,
                                 input logic [tmc_pkg::DATA_W-1:0] oy);
      settle_pipeline();
      csr_write(tmc_pkg::REG_CAL_ENABLE, en);
      csr_write(tmc_pkg::REG_GAIN_X, gx);
      csr_write(tmc_pkg::REG_OFFSET_X, ox);
      csr_write(tmc_pkg::REG_GAIN_Y, gy);
      csr_write(tmc_pkg::REG_OFFSET_Y, oy);
      csr_read_check(tmc_pkg::REG_CAL_ENABLE);
      csr_read_check(tmc_pkg::REG_GAIN_X);
      csr_read_check(tmc_pkg::REG_OFFSET_X);
      csr_read_check(tmc_pkg::REG_GAIN_Y);
      csr_read_check(tmc_pkg::REG_OFFSET_Y);
   endtask

   task automatic run_traffic(input int count);
      int   burst_left;
      int   gap;
      int   pause_at;
      int   center [2];
      bit   sticky;
      logic f;
      burst_left = 0;
      center[0] = $urandom_range(0, tmc_pkg::FULL_SCALE);
      center[1] = $urandom_range(0, tmc_pkg::FULL_SCALE);
      sticky = $urandom_range(0, 1);
      pause_at = $urandom_range(count / 4, 3 * count / 4);
      f = $urandom_range(0, 1);
      for (int i = 0; i < count; i++) begin
         if (i == pause_at)
            hold_until_drained();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (!(sticky && $urandom_range(0, 3) != 0))
            f = $urandom_range(0, 1);
         send_sample(f, pick_sample(center[f]));
         burst_left--;
      end
   endtask

   task automatic test_reset_registers();
      csr_read_check(tmc_pkg::REG_CAL_ENABLE);
      csr_read_check(tmc_pkg::REG_GAIN_X);
      csr_read_check(tmc_pkg::REG_OFFSET_X);
      csr_read_check(tmc_pkg::REG_GAIN_Y);
      csr_read_check(tmc_pkg::REG_OFFSET_Y);
   endtask

   // interleaved axes, duplicated extremes on x, all-equal batch on y
   task automatic test_directed_batches();
      logic [tmc_pkg::SAMPLE_W-1:0] x_set [tmc_pkg::SAMPLES];
      x_set = '{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'h800,
                12'h001, 12'hFFE, 12'hAAA, 12'h555, 12'h064};
      for (int i = 0; i < tmc_pkg::SAMPLES; i++) begin
         send_sample(1'b0, x_set[i]);
         send_sample(1'b1, 12'h9C4);
      end
      send_sample(1'b1, 12'hFFF);
      send_sample(1'b0, 12'h000);
      settle_pipeline();
   endtask

   task automatic test_spare_registers();
      for (int idx = REG_SPARE_FIRST; idx < (1 << tmc_pkg::REG_IDX_W); idx++)
         csr_write(idx[tmc_pkg::REG_IDX_W-1:0], $urandom());
      run_traffic(100);
   endtask

   task automatic test_raw_mean();
      apply_settings(32'h0, $urandom(), $urandom(), $urandom(), $urandom());
      run_traffic(200);
   endtask

   task automatic test_saturation();
      apply_settings(32'h1, 32'h007F_FFFF, 32'h7FFF_FFFF, 32'h0080_0000, 32'h8000_0000);
      run_traffic(150);
      apply_settings(32'h1, 32'h0080_0000, 32'h7FFF_FFFF, 32'h007F_FFFF, 32'h8000_0000);
      run_traffic(150);
   endtask

   task automatic test_unity_and_zero();
      apply_settings(32'h1, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
      run_traffic(150);
   endtask

   task automatic test_moderate_calibration();
      apply_settings(32'h1, 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20),
                     32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24),
                     32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20),
                     32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24));
      run_traffic(200);
   endtask

   task automatic test_random_registers();
      apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      run_traffic(150);
   endtask

   task automatic test_reset_values_rewritten();
      apply_settings(32'h1, tmc_pkg::DATA_W'($signed(tmc_pkg::GAIN_X_RESET)),
                     tmc_pkg::OFFSET_X_RESET,
                     tmc_pkg::DATA_W'($signed(tmc_pkg::GAIN_Y_RESET)),
                     tmc_pkg::OFFSET_Y_RESET);
      run_traffic(150);
   endtask

   initial begin
      cal_cfg = '{calibrate_enable: 1'b1,
                  gain_x: tmc_pkg::GAIN_X_RESET, offset_x: tmc_pkg::OFFSET_X_RESET,
                  gain_y: tmc_pkg::GAIN_Y_RESET, offset_y: tmc_pkg::OFFSET_Y_RESET};
      clear_run(0);
      clear_run(1);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_registers();
      test_directed_batches();
      test_spare_registers();
      test_raw_mean();
      test_saturation();
      test_unity_and_zero();
      test_moderate_calibration();
      test_random_registers();
      test_reset_values_rewritten();
      settle_pipeline();
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
